### rtl/core/mtcsv_pkg.sv
// shared types, constants and helper functions of the csv market-data line parser
package mtcsv_pkg;

  localparam int SYMBOL_BYTES = 8;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [3:0] FLD_TIME    = 4'd0;
  localparam logic [3:0] FLD_TYPE    = 4'd1;
  localparam logic [3:0] FLD_SYMBOL  = 4'd2;
  localparam logic [3:0] FLD_BID_PX  = 4'd3;
  localparam logic [3:0] FLD_BID_QTY = 4'd4;
  localparam logic [3:0] FLD_ASK_PX  = 4'd5;
  localparam logic [3:0] FLD_ASK_QTY = 4'd6;
  localparam logic [3:0] FLD_LAST    = 4'd15;

  localparam logic [3:0] FIELDS_MIN   = 4'd2;
  localparam logic [3:0] FIELDS_SYM   = 4'd3;
  localparam logic [3:0] FIELDS_QUOTE = 4'd7;
  localparam logic [3:0] FIELDS_TRADE = 4'd5;

  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [4:0] TS_LEN      = 5'd12;

  localparam logic [47:0] ACC_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [61:0] PMAX      = 62'h7FFF_FFFF_FFFF;
  localparam logic [61:0] PMIN_MAG  = 62'h8000_0000_0000;
  localparam logic [31:0] QTY_MAX   = 32'hFFFF_FFFF;
  localparam logic [13:0] PX_WHOLE  = 14'd10000;
  localparam logic [6:0]  PX_FRAC   = 7'd100;

  typedef enum logic [1:0] {
    KIND_QUOTE = 2'd0,
    KIND_TRADE = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TIME    = 2'd1,
    ERR_MISSING = 2'd2
  } perr_t;

  // record as it leaves the line tokenizer, prices still as raw parts
  typedef struct packed {
    kind_t             kind;
    perr_t             err;
    logic [48:0]       time_ns;
    logic [63:0]       symbol;
    logic [1:0][47:0]  px_whole;
    logic [1:0][47:0]  px_frac;
    logic [1:0]        px_neg;
    logic [1:0][31:0]  qty;
    logic [47:0]       trade_num;
  } line_rec_t;

  typedef struct packed {
    kind_t        kind;
    perr_t        err;
    logic [48:0]  time_ns;
    logic [63:0]  symbol;
    logic [47:0]  first_price;
    logic [31:0]  first_qty;
    logic [47:0]  second_price;
    logic [31:0]  second_qty;
    logic [47:0]  trade_num;
  } out_rec_t;

  // nanosecond weight of each timestamp position, separators weigh zero
  function automatic logic [45:0] ts_weight(input logic [3:0] idx);
    logic [45:0] w;
    unique case (idx)
      4'd0:    w = 46'd36000000000000;
      4'd1:    w = 46'd3600000000000;
      4'd3:    w = 46'd600000000000;
      4'd4:    w = 46'd60000000000;
      4'd6:    w = 46'd10000000000;
      4'd7:    w = 46'd1000000000;
      4'd9:    w = 46'd100000000;
      4'd10:   w = 46'd10000000;
      4'd11:   w = 46'd1000000;
      default: w = 46'd0;
    endcase
    return w;
  endfunction

  // decimal digit append with saturation
  function automatic logic [47:0] acc_digit(input logic [47:0] a, input logic [3:0] d);
    logic [51:0] t;
    t = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {48'd0, d};
    if (t[51:48] != 4'd0) begin
      return ACC_MAX;
    end
    return t[47:0];
  endfunction

  function automatic logic [31:0] make_qty(input logic [47:0] whole, input logic neg);
    if (neg) begin
      return 32'd0;
    end
    if (whole[47:32] != 16'd0) begin
      return QTY_MAX;
    end
    return whole[31:0];
  endfunction

  // signed price from scaled parts, saturated to the signed 48-bit range
  function automatic logic [47:0] make_price(input logic [61:0] ip, input logic [54:0] fp,
                                             input logic neg);
    logic [61:0] fpx;
    logic [61:0] mag;
    logic [62:0] sum;
    fpx = {7'd0, fp};
    mag = 62'd0;
    sum = 63'd0;
    if (neg) begin
      if (ip >= fpx) begin
        mag = ip - fpx;
        if (mag > PMIN_MAG) begin
          mag = PMIN_MAG;
        end
        return 48'd0 - mag[47:0];
      end
      mag = fpx - ip;
      if (mag > PMAX) begin
        mag = PMAX;
      end
      return mag[47:0];
    end
    sum = {1'b0, ip} + {1'b0, fpx};
    if (sum > {1'b0, PMAX}) begin
      return PMAX[47:0];
    end
    return sum[47:0];
  endfunction

endpackage

### rtl/core/mtcsv_tokenizer.sv
// input register, per-byte field tokenizer and line record register
module mtcsv_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  output logic                rec_vld,
  input  logic                rec_rdy,
  output mtcsv_pkg::line_rec_t rec
);
  import mtcsv_pkg::*;

  logic              in_vld_r;
  logic [7:0]        in_char_r;
  logic              in_last_r;

  logic [3:0]        field_idx_r, field_idx_nxt;
  logic [4:0]        char_pos_r, char_pos_nxt;
  logic              skip_r, skip_nxt;
  logic [7:0]        type_char_r, type_char_nxt;
  logic [48:0]       time_acc_r, time_acc_nxt;
  logic [63:0]       sym_r, sym_nxt;
  logic [47:0]       whole_r, whole_nxt;
  logic [47:0]       frac_r, frac_nxt;
  logic [2:0]        nflags_r, nflags_nxt;
  logic [1:0][47:0]  hold_whole_r, hold_whole_nxt;
  logic [1:0][47:0]  hold_frac_r, hold_frac_nxt;
  logic [1:0]        hold_neg_r, hold_neg_nxt;
  logic [1:0][31:0]  hold_qty_r, hold_qty_nxt;
  logic              ts_bad_r, ts_bad_nxt;
  logic [47:0]       trade_cnt_r, trade_cnt_nxt;

  logic              rec_vld_r;
  line_rec_t         rec_r, rec_nxt;
  logic              rec_emit;

  logic              rec_free;
  logic              proc_fire;

  assign rec_free  = !rec_vld_r || rec_rdy;
  assign proc_fire = in_vld_r && (!in_last_r || rec_free);
  assign in_tready = !in_vld_r || proc_fire;
  assign rec_vld   = rec_vld_r;
  assign rec       = rec_r;

  always_comb begin
    logic        is_dig;
    logic [3:0]  dval;
    logic        close;
    logic [45:0] w;
    logic [49:0] tprod;
    logic [3:0]  need;
    kind_t       kind;
    perr_t       err;
    logic        data_ok;

    field_idx_nxt  = field_idx_r;
    char_pos_nxt   = char_pos_r;
    skip_nxt       = skip_r;
    type_char_nxt  = type_char_r;
    time_acc_nxt   = time_acc_r;
    sym_nxt        = sym_r;
    whole_nxt      = whole_r;
    frac_nxt       = frac_r;
    nflags_nxt     = nflags_r;
    hold_whole_nxt = hold_whole_r;
    hold_frac_nxt  = hold_frac_r;
    hold_neg_nxt   = hold_neg_r;
    hold_qty_nxt   = hold_qty_r;
    ts_bad_nxt     = ts_bad_r;
    trade_cnt_nxt  = trade_cnt_r;

    is_dig = (in_char_r >= CH_ZERO) && (in_char_r <= CH_NINE);
    dval   = in_char_r[3:0];
    close  = 1'b0;
    w      = ts_weight(char_pos_r[3:0]);
    tprod  = 50'(dval) * 50'(w);

    if (!skip_r && in_char_r != CH_LF) begin
      if (in_char_r == CH_COMMA) begin
        close = (char_pos_r != 5'd0);
      end else if (field_idx_r == FLD_TIME && char_pos_r == 5'd0 && in_char_r == CH_HASH) begin
        skip_nxt = 1'b1;
      end else begin
        priority if (field_idx_r == FLD_TIME) begin
          if (char_pos_r < TS_LEN && w != 46'd0) begin
            if (is_dig) begin
              time_acc_nxt = time_acc_r + tprod[48:0];
            end else begin
              ts_bad_nxt = 1'b1;
            end
          end
        end else if (field_idx_r == FLD_TYPE) begin
          if (char_pos_r == 5'd0) begin
            type_char_nxt = in_char_r;
          end
        end else if (field_idx_r == FLD_SYMBOL) begin
          for (int i = 0; i < 8; i++) begin
            if (i < SYMBOL_BYTES && char_pos_r == 5'(i)) begin
              sym_nxt[63-8*i -: 8] = sym_r[63-8*i -: 8] | in_char_r;
            end
          end
        end else if (field_idx_r <= FLD_ASK_QTY) begin
          priority if (nflags_r[2]) begin
          end else if (nflags_r[1]) begin
            if (is_dig) begin
              frac_nxt = acc_digit(frac_r, dval);
            end else begin
              nflags_nxt[2] = 1'b1;
            end
          end else if (char_pos_r == 5'd0 && in_char_r == CH_MINUS) begin
            nflags_nxt[0] = 1'b1;
          end else if (is_dig) begin
            whole_nxt = acc_digit(whole_r, dval);
          end else begin
            nflags_nxt[1] = 1'b1;
          end
        end else begin
        end
        if (char_pos_r != POS_MAX) begin
          char_pos_nxt = char_pos_r + 5'd1;
        end
      end
    end

    if (in_last_r && !skip_nxt && char_pos_nxt != 5'd0) begin
      close = 1'b1;
    end

    if (close) begin
      unique case (field_idx_nxt)
        FLD_TIME: begin
          if (char_pos_nxt < TS_LEN) begin
            ts_bad_nxt = 1'b1;
          end
        end
        FLD_BID_PX: begin
          hold_whole_nxt[0] = whole_nxt;
          hold_frac_nxt[0]  = frac_nxt;
          hold_neg_nxt[0]   = nflags_nxt[0];
        end
        FLD_BID_QTY: hold_qty_nxt[0] = make_qty(whole_nxt, nflags_nxt[0]);
        FLD_ASK_PX: begin
          hold_whole_nxt[1] = whole_nxt;
          hold_frac_nxt[1]  = frac_nxt;
          hold_neg_nxt[1]   = nflags_nxt[0];
        end
        FLD_ASK_QTY: hold_qty_nxt[1] = make_qty(whole_nxt, nflags_nxt[0]);
        default: begin
        end
      endcase
      if (field_idx_nxt != FLD_LAST) begin
        field_idx_nxt = field_idx_nxt + 4'd1;
      end
      char_pos_nxt = 5'd0;
      whole_nxt    = 48'd0;
      frac_nxt     = 48'd0;
      nflags_nxt   = 3'd0;
    end

    priority if (type_char_nxt == CH_Q) begin
      kind = KIND_QUOTE;
    end else if (type_char_nxt == CH_T) begin
      kind = KIND_TRADE;
    end else begin
      kind = KIND_OTHER;
    end
    need = (kind == KIND_QUOTE) ? FIELDS_QUOTE : FIELDS_TRADE;
    err  = ERR_NONE;
    if (field_idx_nxt < FIELDS_MIN) begin
      kind = KIND_OTHER;
      err  = ERR_MISSING;
    end else if (kind != KIND_OTHER) begin
      priority if (field_idx_nxt < FIELDS_SYM) begin
        err = ERR_MISSING;
      end else if (ts_bad_nxt) begin
        err = ERR_TIME;
      end else if (field_idx_nxt < need) begin
        err = ERR_MISSING;
      end else begin
        err = ERR_NONE;
      end
    end
    data_ok = (err == ERR_NONE) && (kind != KIND_OTHER);

    rec_nxt      = '0;
    rec_nxt.kind = kind;
    rec_nxt.err  = err;
    if (data_ok) begin
      rec_nxt.time_ns     = time_acc_nxt;
      rec_nxt.symbol      = sym_nxt;
      rec_nxt.px_whole[0] = hold_whole_nxt[0];
      rec_nxt.px_frac[0]  = hold_frac_nxt[0];
      rec_nxt.px_neg[0]   = hold_neg_nxt[0];
      rec_nxt.qty[0]      = hold_qty_nxt[0];
      if (kind == KIND_QUOTE) begin
        rec_nxt.px_whole[1] = hold_whole_nxt[1];
        rec_nxt.px_frac[1]  = hold_frac_nxt[1];
        rec_nxt.px_neg[1]   = hold_neg_nxt[1];
        rec_nxt.qty[1]      = hold_qty_nxt[1];
      end else begin
        rec_nxt.trade_num = trade_cnt_r;
      end
    end

    rec_emit = proc_fire && in_last_r && !skip_nxt;
    if (rec_emit && data_ok && kind == KIND_TRADE) begin
      trade_cnt_nxt = trade_cnt_r + 48'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_char;
      in_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_idx_r  <= 4'd0;
      char_pos_r   <= 5'd0;
      skip_r       <= 1'b0;
      type_char_r  <= 8'd0;
      time_acc_r   <= 49'd0;
      sym_r        <= 64'd0;
      whole_r      <= 48'd0;
      frac_r       <= 48'd0;
      nflags_r     <= 3'd0;
      hold_whole_r <= '0;
      hold_frac_r  <= '0;
      hold_neg_r   <= 2'd0;
      hold_qty_r   <= '0;
      ts_bad_r     <= 1'b0;
      trade_cnt_r  <= 48'd1;
    end else if (proc_fire) begin
      trade_cnt_r <= trade_cnt_nxt;
      if (in_last_r) begin
        field_idx_r  <= 4'd0;
        char_pos_r   <= 5'd0;
        skip_r       <= 1'b0;
        type_char_r  <= 8'd0;
        time_acc_r   <= 49'd0;
        sym_r        <= 64'd0;
        whole_r      <= 48'd0;
        frac_r       <= 48'd0;
        nflags_r     <= 3'd0;
        hold_whole_r <= '0;
        hold_frac_r  <= '0;
        hold_neg_r   <= 2'd0;
        hold_qty_r   <= '0;
        ts_bad_r     <= 1'b0;
      end else begin
        field_idx_r  <= field_idx_nxt;
        char_pos_r   <= char_pos_nxt;
        skip_r       <= skip_nxt;
        type_char_r  <= type_char_nxt;
        time_acc_r   <= time_acc_nxt;
        sym_r        <= sym_nxt;
        whole_r      <= whole_nxt;
        frac_r       <= frac_nxt;
        nflags_r     <= nflags_nxt;
        hold_whole_r <= hold_whole_nxt;
        hold_frac_r  <= hold_frac_nxt;
        hold_neg_r   <= hold_neg_nxt;
        hold_qty_r   <= hold_qty_nxt;
        ts_bad_r     <= ts_bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= 1'b0;
    end else if (rec_free) begin
      rec_vld_r <= rec_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_free && rec_emit) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

### rtl/core/mtcsv_price_pipe.sv
// price scaling: product register, then saturating combine into the output register
module mtcsv_price_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_vld,
  output logic                 rec_rdy,
  input  mtcsv_pkg::line_rec_t rec,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output mtcsv_pkg::out_rec_t  out_rec
);
  import mtcsv_pkg::*;

  logic              p1_vld_r;
  line_rec_t         p1_rec_r;
  logic [1:0][61:0]  p1_ip_r;
  logic [1:0][54:0]  p1_fp_r;

  logic              out_vld_r;
  out_rec_t          out_r, out_nxt;

  logic              load_out;
  logic              load_p1;

  assign load_out = p1_vld_r && (!out_vld_r || out_rdy);
  assign rec_rdy  = !p1_vld_r || load_out;
  assign load_p1  = rec_vld && rec_rdy;
  assign out_vld  = out_vld_r;
  assign out_rec  = out_r;

  always_comb begin
    out_nxt              = '0;
    out_nxt.kind         = p1_rec_r.kind;
    out_nxt.err          = p1_rec_r.err;
    out_nxt.time_ns      = p1_rec_r.time_ns;
    out_nxt.symbol       = p1_rec_r.symbol;
    out_nxt.first_price  = make_price(p1_ip_r[0], p1_fp_r[0], p1_rec_r.px_neg[0]);
    out_nxt.first_qty    = p1_rec_r.qty[0];
    out_nxt.second_price = make_price(p1_ip_r[1], p1_fp_r[1], p1_rec_r.px_neg[1]);
    out_nxt.second_qty   = p1_rec_r.qty[1];
    out_nxt.trade_num    = p1_rec_r.trade_num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (rec_rdy) begin
      p1_vld_r <= rec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load_p1) begin
      p1_rec_r <= rec;
      for (int i = 0; i < 2; i++) begin
        p1_ip_r[i] <= 62'(rec.px_whole[i]) * 62'(PX_WHOLE);
        p1_fp_r[i] <= 55'(rec.px_frac[i]) * 55'(PX_FRAC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_rdy) begin
      out_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

endmodule

### rtl/core/market_tick_csv_line_parser.sv
// top level of the csv market-data line parser: byte stream in, one record per line out, except lines that begin with #
//
//  channel | dir | tdata                          | tuser              | tlast
//  in_     | in  | char_in [7:0]                  | -                  | line_end
//  out_    | out | time_ns .. trade_number [320:0] | kind, error [3:0]  | -
//
// one byte word accepted per clock while the record path is not stalled, lines may follow each other with no gap
// a record is carried from the word with line_end, once that word is accepted, through these registers in order:
// input register, tokenizer record register, price product register, output register
// each stage holds while the next is full, so stalls only back up as far as needed
// rst_n clears all stage valids and line state, the trade counter restarts at one
module market_tick_csv_line_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // char_in[7:0]
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [327:0]  out_tdata,  // time_ns[48:0], symbol_chars[112:49],
                                    // first_price[160:113], first_qty[192:161],
                                    // second_price[240:193], second_qty[272:241],
                                    // trade_number[320:273], zero pad[327:321]
  output logic [3:0]    out_tuser   // record_kind[1:0], parse_error[3:2]
);
  import mtcsv_pkg::*;

  logic       rec_vld;
  logic       rec_rdy;
  line_rec_t  rec;
  out_rec_t   out_rec;

  mtcsv_tokenizer u_tokenizer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .rec_vld   (rec_vld),
    .rec_rdy   (rec_rdy),
    .rec       (rec)
  );

  mtcsv_price_pipe u_price_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .rec_vld (rec_vld),
    .rec_rdy (rec_rdy),
    .rec     (rec),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_rec (out_rec)
  );

  assign out_tdata = {7'd0, out_rec.trade_num, out_rec.second_qty, out_rec.second_price,
                      out_rec.first_qty, out_rec.first_price, out_rec.symbol,
                      out_rec.time_ns};
  assign out_tuser = {out_rec.err, out_rec.kind};

endmodule
